>>> src/qwpi_pkg.sv
// ----------------------------------------------------------------------------
// qwpi_pkg - shared types and constants of the quad wheel PI speed controller
// Field widths, register reset values, register indexes, pipeline depth and
// the reciprocal constants used for the voltage to command scaling.
// ----------------------------------------------------------------------------
package qwpi_pkg;

  localparam int SLOTS           = 4;
  localparam int WHEEL_COUNT_DEF = 4;

  localparam int SPEED_W = 16;
  localparam int CMD_W   = 16;

  localparam int PGAIN_W = 24;
  localparam int IGAIN_W = 24;
  localparam int GEAR_W  = 8;
  localparam int TSTEP_W = 16;
  localparam int VLIM_W  = 13;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int ERR_W   = 25;
  localparam int INTEG_W = 40;

  // Lane stages plus the merge/output stage.
  localparam int STAGES = 9;

  localparam logic [PGAIN_W-1:0] PGAIN_RST = PGAIN_W'(53674);
  localparam logic [IGAIN_W-1:0] IGAIN_RST = IGAIN_W'(11311514);
  localparam logic [GEAR_W-1:0]  GEAR_RST  = GEAR_W'(19);
  localparam logic [TSTEP_W-1:0] TSTEP_RST = TSTEP_W'(655);
  localparam logic [VLIM_W-1:0]  VLIM_RST  = VLIM_W'(5530);

  // command = round_half_away(|v| * 125 / 27), done as
  // ((|v| * 125 + 13) * M) >> DIV_SHIFT with M = ceil(2^25 / 27).
  localparam int DIV_SHIFT  = 25;
  localparam int DIV_PROD_W = 41;
  localparam int DIV_MUL    = 155344625;  // 125 * M
  localparam int DIV_ADD    = 16155841;   // 13 * M

  localparam int CMD_LIMIT = 25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_GEAR_RATIO    = 3'd2,
    REG_TIME_STEP     = 3'd3,
    REG_VOLTAGE_LIMIT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [PGAIN_W-1:0] prop_gain;
    logic [IGAIN_W-1:0] integ_gain;
    logic [GEAR_W-1:0]  gear_ratio;
    logic [TSTEP_W-1:0] time_step;
    logic [VLIM_W-1:0]  voltage_limit;
  } cfg_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

>>> src/quad_wheel_pi_speed_controller.sv
// ----------------------------------------------------------------------------
// quad_wheel_pi_speed_controller - four-wheel PI speed controller, top level
// One request per control tick: four reference and four measured wheel
// speeds in, four clamped drive commands out.
// ----------------------------------------------------------------------------
// Usage
//   s_*   : one request per tick; tdata = ref_speed_a..d, meas_speed_a..d,
//           16 bits each, lowest bits first.
//   m_*   : one result per request; tdata = drive_cmd_a..d, 16 bits each.
//   cfg_* : register writes (index 0 prop_gain .. 4 voltage_limit), ready
//           outside reset; write only while no request is in flight. Other
//           indexes are dropped.
//   Pipeline: nine stages from the accepting edge to m_tvalid.
//   Throughput: one request per cycle while m_tready is high; each wheel has
//   its own lane and the integrator adds and saturates within its own stage.
//   Reset: integrators clear, registers take their defaults, pipeline
//   empties; s_tready and cfg_ready stay low while rst is high.
//   Stall: when m_tready is low the output holds; earlier stages keep filling
//   their empty slots, and s_tready drops once every stage is occupied.
// ----------------------------------------------------------------------------
module quad_wheel_pi_speed_controller #(
  parameter int WHEEL_COUNT = qwpi_pkg::WHEEL_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // ref_speed_a, ref_speed_b, ref_speed_c, ref_speed_d,
  // meas_speed_a, meas_speed_b, meas_speed_c, meas_speed_d
  input  logic [2*qwpi_pkg::SLOTS*qwpi_pkg::SPEED_W-1:0] s_tdata,
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // drive_cmd_a, drive_cmd_b, drive_cmd_c, drive_cmd_d
  output logic [qwpi_pkg::SLOTS*qwpi_pkg::CMD_W-1:0]     m_tdata,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [qwpi_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [qwpi_pkg::CFG_DATA_W-1:0]               cfg_data
);

  localparam int SW = qwpi_pkg::SPEED_W;
  localparam int NS = qwpi_pkg::SLOTS;

  qwpi_pkg::cfg_t      cfg;
  qwpi_pkg::pipe_ctl_t ctl;

  logic [NS-1:0][qwpi_pkg::DIV_PROD_W-1:0] lane_scaled;
  logic [NS-1:0]                           lane_neg;

  // Configuration registers; writes are registered and accepted outside reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= qwpi_pkg::PGAIN_RST;
      cfg.integ_gain    <= qwpi_pkg::IGAIN_RST;
      cfg.gear_ratio    <= qwpi_pkg::GEAR_RST;
      cfg.time_step     <= qwpi_pkg::TSTEP_RST;
      cfg.voltage_limit <= qwpi_pkg::VLIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (qwpi_pkg::reg_index_t'(cfg_index))
        qwpi_pkg::REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[qwpi_pkg::PGAIN_W-1:0];
        qwpi_pkg::REG_INTEG_GAIN:    cfg.integ_gain    <= cfg_data[qwpi_pkg::IGAIN_W-1:0];
        qwpi_pkg::REG_GEAR_RATIO:    cfg.gear_ratio    <= cfg_data[qwpi_pkg::GEAR_W-1:0];
        qwpi_pkg::REG_TIME_STEP:     cfg.time_step     <= cfg_data[qwpi_pkg::TSTEP_W-1:0];
        qwpi_pkg::REG_VOLTAGE_LIMIT: cfg.voltage_limit <= cfg_data[qwpi_pkg::VLIM_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Flow control shared by all lanes and the merge stage.
  qwpi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  // One lane per wheel in use; unused slots feed zeros to the merge.
  for (genvar w = 0; w < NS; w++) begin : g_lane
    if (w < WHEEL_COUNT) begin : g_used
      qwpi_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .cfg        (cfg),
        .ctl        (ctl),
        .ref_speed  ($signed(s_tdata[w*SW +: SW])),
        .meas_speed ($signed(s_tdata[(NS + w)*SW +: SW])),
        .scaled     (lane_scaled[w]),
        .neg        (lane_neg[w])
      );
    end else begin : g_unused
      assign lane_scaled[w] = '0;
      assign lane_neg[w]    = 1'b0;
    end
  end

  // Merge the lanes into the output register.
  qwpi_merge #(
    .WHEEL_COUNT (WHEEL_COUNT)
  ) u_merge (
    .clk    (clk),
    .ctl    (ctl),
    .scaled (lane_scaled),
    .neg    (lane_neg),
    .tdata  (m_tdata)
  );

endmodule

>>> src/qwpi_ctrl.sv
// ----------------------------------------------------------------------------
// qwpi_ctrl - pipeline flow control
// Keeps one valid bit per stage and loads a stage whenever it is empty or its
// content moves on, so bubbles collapse and input keeps flowing under stall.
// ----------------------------------------------------------------------------
module qwpi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output qwpi_pkg::pipe_ctl_t  ctl
);

  localparam int N = qwpi_pkg::STAGES;

  logic [N-1:0] vld;
  logic [N-1:0] upstream;
  logic [N:0]   rdy;

  assign upstream = {vld[N-2:0], s_tvalid};

  always_comb begin
    rdy[N] = m_tready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    ctl.load = upstream & rdy[N-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      // take a new request, or hold the current one while downstream is stuck
      vld <= ctl.load | (vld & ~rdy[N:1]);
    end
  end

  // refuse requests while reset clears the pipeline
  assign s_tready = rdy[0] && !rst;
  assign m_tvalid = vld[N-1];

endmodule

>>> src/qwpi_lane.sv
// ----------------------------------------------------------------------------
// qwpi_lane - one wheel's PI datapath
// Error, integrator with saturation, P and I terms, voltage clamp and the
// reciprocal product for the command scaling, over eight registered stages.
// ----------------------------------------------------------------------------
module qwpi_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  qwpi_pkg::cfg_t                         cfg,
  input  qwpi_pkg::pipe_ctl_t                    ctl,
  input  logic signed [qwpi_pkg::SPEED_W-1:0]    ref_speed,
  input  logic signed [qwpi_pkg::SPEED_W-1:0]    meas_speed,
  output logic        [qwpi_pkg::DIV_PROD_W-1:0] scaled,
  output logic                                   neg
);

  localparam int EW = qwpi_pkg::ERR_W;
  localparam int IW = qwpi_pkg::INTEG_W;
  localparam int PW = qwpi_pkg::DIV_PROD_W;

  localparam logic signed [IW-1:0] INTEG_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INTEG_MIN = {1'b1, {(IW-1){1'b0}}};

  // stage 1: motor speed error
  logic signed [16:0]   diff;
  logic signed [25:0]   err_full;
  logic signed [EW-1:0] err_s1;

  // stage 2: raw products
  logic signed [41:0] incp_full;
  logic signed [49:0] pp_full;
  logic signed [40:0] inc_prod_s2;
  logic signed [48:0] p_prod_s2;

  // stage 3: rounded increment and P term
  logic signed [40:0] inc_rnd;
  logic signed [48:0] p_rnd;
  logic signed [32:0] inc_s3;
  logic signed [32:0] p_s3;

  // stage 4: integrator
  logic signed [IW:0]   integ_sum;
  logic signed [IW-1:0] integ;
  logic signed [32:0]   p_s4;

  // stage 5: split I product
  logic        [43:0] lo_full;
  logic signed [44:0] hi_full;
  logic        [43:0] lo_s5;
  logic signed [44:0] hi_s5;
  logic signed [32:0] p_s5;

  // stage 6: I term
  logic signed [64:0] i_full;
  logic signed [40:0] i_s6;
  logic signed [32:0] p_s6;

  // stage 7: clamped voltage
  logic signed [41:0] v_full;
  logic signed [41:0] lim;
  logic signed [41:0] v_clamp;
  logic signed [13:0] v_s7;

  // stage 8: reciprocal product
  logic signed [13:0] v_neg;
  logic        [12:0] mag;

  assign diff     = {ref_speed[15], ref_speed} - {meas_speed[15], meas_speed};
  assign err_full = diff * $signed({1'b0, cfg.gear_ratio});

  assign incp_full = err_s1 * $signed({1'b0, cfg.time_step});
  assign pp_full   = err_s1 * $signed({1'b0, cfg.prop_gain});

  assign inc_rnd = inc_prod_s2 + 41'sd128;
  assign p_rnd   = p_prod_s2 + 49'sd32768;

  assign integ_sum = {integ[IW-1], integ} + {{(IW + 1 - 33){inc_s3[32]}}, inc_s3};

  assign lo_full = integ[19:0] * cfg.integ_gain;
  assign hi_full = $signed(integ[IW-1:20]) * $signed({1'b0, cfg.integ_gain});

  assign i_full = $signed({hi_s5, 20'd0}) + $signed({21'd0, lo_s5}) + 65'sd8388608;

  assign v_full = {i_s6[40], i_s6} + {{9{p_s6[32]}}, p_s6};
  assign lim    = $signed({29'd0, cfg.voltage_limit});

  always_comb begin
    if (v_full > lim) begin
      v_clamp = lim;
    end else if (v_full < -lim) begin
      v_clamp = -lim;
    end else begin
      v_clamp = v_full;
    end
  end

  assign v_neg = -v_s7;
  assign mag   = v_s7[13] ? v_neg[12:0] : v_s7[12:0];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      err_s1 <= err_full[EW-1:0];
    end
    if (ctl.load[1]) begin
      inc_prod_s2 <= incp_full[40:0];
      p_prod_s2   <= pp_full[48:0];
    end
    if (ctl.load[2]) begin
      inc_s3 <= inc_rnd[40:8];
      p_s3   <= p_rnd[48:16];
    end
    if (ctl.load[3]) begin
      p_s4 <= p_s3;
    end
    if (ctl.load[4]) begin
      lo_s5 <= lo_full;
      hi_s5 <= hi_full;
      p_s5  <= p_s4;
    end
    if (ctl.load[5]) begin
      i_s6 <= i_full[64:24];
      p_s6 <= p_s5;
    end
    if (ctl.load[6]) begin
      v_s7 <= v_clamp[13:0];
    end
    if (ctl.load[7]) begin
      scaled <= PW'(mag) * PW'(qwpi_pkg::DIV_MUL) + PW'(qwpi_pkg::DIV_ADD);
      neg    <= v_s7[13];
    end
  end

  // integrator is state: cleared at reset, saturated after each add
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (ctl.load[3]) begin
      if (integ_sum[IW] != integ_sum[IW-1]) begin
        integ <= integ_sum[IW] ? INTEG_MIN : INTEG_MAX;
      end else begin
        integ <= integ_sum[IW-1:0];
      end
    end
  end

endmodule

>>> src/qwpi_merge.sv
// ----------------------------------------------------------------------------
// qwpi_merge - command merge and output register
// Finishes each lane's division, saturates and signs the command, zeroes
// unused wheel slots and packs all slots into the output word.
// ----------------------------------------------------------------------------
module qwpi_merge #(
  parameter int WHEEL_COUNT = qwpi_pkg::WHEEL_COUNT_DEF
) (
  input  logic                                              clk,
  input  qwpi_pkg::pipe_ctl_t                               ctl,
  input  logic [qwpi_pkg::SLOTS-1:0][qwpi_pkg::DIV_PROD_W-1:0] scaled,
  input  logic [qwpi_pkg::SLOTS-1:0]                        neg,
  output logic [qwpi_pkg::SLOTS*qwpi_pkg::CMD_W-1:0]        tdata
);

  localparam int QW = qwpi_pkg::DIV_PROD_W - qwpi_pkg::DIV_SHIFT;
  localparam int CW = qwpi_pkg::CMD_W;
  localparam logic [QW-1:0] QLIM = QW'(qwpi_pkg::CMD_LIMIT);

  logic [qwpi_pkg::SLOTS-1:0][CW-1:0] cmd_next;

  always_comb begin
    logic [QW-1:0] q;
    logic [CW-1:0] qc;
    for (int w = 0; w < qwpi_pkg::SLOTS; w++) begin
      q  = scaled[w][qwpi_pkg::DIV_PROD_W-1:qwpi_pkg::DIV_SHIFT];
      qc = CW'((q > QLIM) ? QLIM : q);
      if (w >= WHEEL_COUNT) begin
        cmd_next[w] = '0;
      end else if (neg[w]) begin
        cmd_next[w] = -qc;
      end else begin
        cmd_next[w] = qc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[qwpi_pkg::STAGES-1]) begin
      tdata <= cmd_next;
    end
  end

endmodule

>>> src/qwpi_checker.sv
// ----------------------------------------------------------------------------
// qwpi_checker - port-level checks for the quad wheel PI speed controller
// Output handshake stability, reset behavior, input readiness and command range.
// ----------------------------------------------------------------------------
module qwpi_checker (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          s_tready,
  input logic                                          m_tvalid,
  input logic                                          m_tready,
  input logic [qwpi_pkg::SLOTS*qwpi_pkg::CMD_W-1:0]     m_tdata
);

  localparam logic signed [15:0] LIM = 16'(qwpi_pkg::CMD_LIMIT);

  logic signed [15:0] cmd_a, cmd_b, cmd_c, cmd_d;

  assign cmd_a = $signed(m_tdata[15:0]);
  assign cmd_b = $signed(m_tdata[31:16]);
  assign cmd_c = $signed(m_tdata[47:32]);
  assign cmd_d = $signed(m_tdata[63:48]);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped under stall");

  // a stalled result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed under stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // with no result waiting the input side is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("s_tready low with an empty output");

  // every command is saturated to the drive range
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cmd_a <= LIM && cmd_a >= -LIM && cmd_b <= LIM && cmd_b >= -LIM &&
                  cmd_c <= LIM && cmd_c >= -LIM && cmd_d <= LIM && cmd_d >= -LIM))
    else $error("drive command out of range");

endmodule

bind quad_wheel_pi_speed_controller qwpi_checker u_qwpi_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
